[design/kmeans_color_segmenter_core_defines.svh]
// kmeans_color_segmenter_core_defines.svh: assertion macros
`ifndef KMEANS_COLOR_SEGMENTER_CORE_DEFINES_SVH
`define KMEANS_COLOR_SEGMENTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// a property that must hold at every enabled edge
`define KCS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// a property that must hold in the cycle after a trigger
`define KCS_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);
`else
`define KCS_ASSERT(label, clk, rst_n, prop, msg)
`define KCS_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg)
`endif
`endif

[design/kcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcs_pkg: shared types and codes
// Mode codes and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package kcs_pkg;
    localparam logic [1:0] MODE_LOAD     = 2'd0;
    localparam logic [1:0] MODE_CLASSIFY = 2'd1;
    localparam logic [1:0] MODE_FINISH   = 2'd2;
    localparam logic [1:0] MODE_RECOLOR  = 2'd3;
    localparam int CH_BITS = 8;

    typedef struct packed {
        logic       capture;    // take the input beat
        logic       load;       // write centroid slot
        logic       classify;   // run nearest search on captured pixel
        logic       accum;      // add pixel to winner's sums
        logic       div_start;  // start averaging of cluster div_idx
        logic [2:0] div_idx;
        logic       emit_class; // result from classify / recolor
        logic       emit_avg;   // result from averaging
        logic       recolor;    // colour fields from average table
        logic       last;
        logic       out_pop;    // output register drained
    } kcs_cmd_t;

    typedef struct packed {
        logic       search_done;
        logic       div_done;
        logic       out_full;
    } kcs_status_t;
endpackage
`default_nettype wire

[design/kcs_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcs_datapath: centroid, sum and average storage with search and divide
// Serial nearest search (one centroid a cycle) and a restoring divider
// shared by the three channels (one quotient bit a cycle each).
// ----------------------------------------------------------------------------
module kcs_datapath
    import kcs_pkg::*;
#(
    parameter int CLUSTERS   = 6,
    parameter int COUNT_BITS = 22
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire kcs_cmd_t            cmd,
    output kcs_status_t              status,
    input  wire logic [2:0]          in_index,
    input  wire logic [7:0]          in_blue,
    input  wire logic [7:0]          in_green,
    input  wire logic [7:0]          in_red,
    output logic [2:0]               label,
    output logic [7:0]               out_blue,
    output logic [7:0]               out_green,
    output logic [7:0]               out_red,
    output logic                     last,
    output logic                     valid
);
    localparam int SUM_BITS = COUNT_BITS + CH_BITS;
    localparam int IDX_BITS = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
    localparam int DEN_BITS = COUNT_BITS + 1;
    localparam int NUM_BITS = SUM_BITS + 1;
    localparam int STEPS    = CH_BITS + 1;
    localparam int STEP_BITS = $clog2(STEPS + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // captured pixel
    logic [7:0] pix_reg [3];
    // storage, cleared at reset
    logic [7:0]            cen_reg [CLUSTERS][3];
    logic [7:0]            avg_reg [CLUSTERS][3];
    logic [SUM_BITS-1:0]   sum_reg [CLUSTERS][3];
    logic [COUNT_BITS-1:0] cnt_reg [CLUSTERS];

    // search state
    logic [IDX_BITS-1:0] scan_reg;
    logic [IDX_BITS-1:0] best_reg;
    logic [17:0]         best_d_reg;
    logic                searching_reg;
    logic                search_done_reg;

    // distance to the centroid under scan
    logic [8:0]  df [3];
    logic [17:0] sq_dist;
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            df[c] = (pix_reg[c] > cen_reg[scan_reg][c]) ?
                    {1'b0, pix_reg[c] - cen_reg[scan_reg][c]} :
                    {1'b0, cen_reg[scan_reg][c] - pix_reg[c]};
        end
        sq_dist = 18'(df[0][7:0] * df[0][7:0]) + 18'(df[1][7:0] * df[1][7:0])
                + 18'(df[2][7:0] * df[2][7:0]);
    end

    // divider state: q = (2*sum + cnt) / (2*cnt)
    logic [NUM_BITS-1:0]  rem_reg [3];
    logic [7:0]           quo_reg [3];
    logic [DEN_BITS:0]    den_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic                 div_busy_reg;
    logic                 div_done_reg;
    logic [IDX_BITS-1:0]  div_idx_reg;
    logic [DEN_BITS+CH_BITS:0] shd;
    logic [2:0]          fits;
    always_comb
    begin
        // divisor aligned to quotient bit (7 - step)
        shd = {den_reg, {CH_BITS{1'b0}}} >> (step_reg + 1'b1);
        for (int c = 0; c < 3; c++)
            fits[c] = ({{(DEN_BITS+CH_BITS-NUM_BITS+1){1'b0}}, rem_reg[c]} >= shd);
    end

    logic [IDX_BITS-1:0] acc_idx;
    logic [IDX_BITS-1:0] cmd_idx;
    assign acc_idx = best_reg;
    assign cmd_idx = cmd.div_idx[IDX_BITS-1:0];

    // output register
    logic       valid_reg;
    logic [2:0] label_reg;
    logic [7:0] ob_reg, og_reg, or_reg;
    logic       last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CLUSTERS; k++)
            begin
                cnt_reg[k] <= '0;
                for (int c = 0; c < 3; c++)
                begin
                    cen_reg[k][c] <= '0;
                    avg_reg[k][c] <= '0;
                    sum_reg[k][c] <= '0;
                end
            end
            searching_reg   <= 1'b0;
            search_done_reg <= 1'b0;
            div_busy_reg    <= 1'b0;
            div_done_reg    <= 1'b0;
            valid_reg       <= 1'b0;
            scan_reg        <= '0;
            best_reg        <= '0;
        end
        else
        begin
            search_done_reg <= 1'b0;
            div_done_reg    <= 1'b0;
            if (cmd.capture)
            begin
                pix_reg[0] <= in_blue;
                pix_reg[1] <= in_green;
                pix_reg[2] <= in_red;
            end
            // centroid load
            if (cmd.load && (32'(in_index) < CLUSTERS))
            begin
                cen_reg[in_index[IDX_BITS-1:0]][0] <= in_blue;
                cen_reg[in_index[IDX_BITS-1:0]][1] <= in_green;
                cen_reg[in_index[IDX_BITS-1:0]][2] <= in_red;
            end
            // serial nearest search
            if (cmd.classify)
            begin
                searching_reg <= 1'b1;
                scan_reg      <= '0;
            end
            else if (searching_reg)
            begin
                if (scan_reg == '0 || sq_dist < best_d_reg)
                begin
                    best_d_reg <= sq_dist;
                    best_reg   <= scan_reg;
                end
                if (32'(scan_reg) == CLUSTERS - 1)
                begin
                    searching_reg   <= 1'b0;
                    search_done_reg <= 1'b1;
                end
                else
                    scan_reg <= scan_reg + 1'b1;
            end
            // accumulate with count saturation
            if (cmd.accum && cnt_reg[acc_idx] != COUNT_MAX)
            begin
                cnt_reg[acc_idx] <= cnt_reg[acc_idx] + 1'b1;
                for (int c = 0; c < 3; c++)
                    sum_reg[acc_idx][c] <= sum_reg[acc_idx][c] + SUM_BITS'(pix_reg[c]);
            end
            // averaging divider
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_idx_reg  <= cmd_idx;
                step_reg     <= '0;
                den_reg      <= {1'b0, cnt_reg[cmd_idx], 1'b0};
                for (int c = 0; c < 3; c++)
                begin
                    rem_reg[c] <= {sum_reg[cmd_idx][c], 1'b0}
                                + NUM_BITS'(cnt_reg[cmd_idx]);
                    quo_reg[c] <= '0;
                end
            end
            else if (div_busy_reg)
            begin
                if (32'(step_reg) == STEPS - 1)
                begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                    for (int c = 0; c < 3; c++)
                    begin
                        avg_reg[div_idx_reg][c] <= (den_reg == '0) ? 8'd0 : quo_reg[c];
                        sum_reg[div_idx_reg][c] <= '0;
                    end
                    cnt_reg[div_idx_reg] <= '0;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                    // one quotient bit a step, most significant first
                    for (int c = 0; c < 3; c++)
                        if (den_reg != '0)
                        begin
                            quo_reg[c] <= {quo_reg[c][6:0], fits[c]};
                            if (fits[c])
                                rem_reg[c] <= NUM_BITS'(
                                    {{(DEN_BITS+CH_BITS-NUM_BITS+1){1'b0}}, rem_reg[c]}
                                    - shd);
                        end
                end
            end
            // output register
            if (cmd.emit_class)
            begin
                valid_reg <= 1'b1;
                label_reg <= 3'(best_reg);
                ob_reg    <= cmd.recolor ? avg_reg[best_reg][0] : 8'd0;
                og_reg    <= cmd.recolor ? avg_reg[best_reg][1] : 8'd0;
                or_reg    <= cmd.recolor ? avg_reg[best_reg][2] : 8'd0;
                last_reg  <= 1'b1;
            end
            else if (cmd.emit_avg)
            begin
                valid_reg <= 1'b1;
                label_reg <= 3'(div_idx_reg);
                ob_reg    <= avg_reg[div_idx_reg][0];
                og_reg    <= avg_reg[div_idx_reg][1];
                or_reg    <= avg_reg[div_idx_reg][2];
                last_reg  <= cmd.last;
            end
            else if (cmd.out_pop)
                valid_reg <= 1'b0;
        end
    end

    assign status.search_done = search_done_reg;
    assign status.div_done    = div_done_reg;
    assign status.out_full    = valid_reg;
    assign valid     = valid_reg;
    assign label     = label_reg;
    assign out_blue  = ob_reg;
    assign out_green = og_reg;
    assign out_red   = or_reg;
    assign last      = last_reg;
endmodule
`default_nettype wire

[design/kcs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcs_ctrl: sequencer
// Takes one beat at a time and steps the datapath through search, update,
// averaging and result hand-off.
// ----------------------------------------------------------------------------
module kcs_ctrl
    import kcs_pkg::*;
#(
    parameter int CLUSTERS = 6
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  in_mode,
    input  wire logic        out_stall,
    input  wire kcs_status_t status,
    output kcs_cmd_t         cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_EMIT, S_DIV, S_DIV_EMIT, S_DRAIN
    } state_t;

    state_t     state_reg;
    logic       recolor_reg;
    logic [2:0] k_reg;
    logic       pop;

    assign pop      = status.out_full && !out_stall;
    assign in_stall = (state_reg != S_IDLE) || (status.out_full && !pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            recolor_reg <= 1'b0;
            k_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (in_valid && !in_stall)
                    begin
                        case (in_mode)
                            MODE_CLASSIFY: begin recolor_reg <= 1'b0; state_reg <= S_SEARCH; end
                            MODE_RECOLOR:  begin recolor_reg <= 1'b1; state_reg <= S_SEARCH; end
                            MODE_FINISH:   begin k_reg <= '0; state_reg <= S_DIV; end
                            default:       state_reg <= S_IDLE;
                        endcase
                    end
                S_SEARCH:
                    if (status.search_done)
                        state_reg <= S_IDLE;
                S_DIV:
                    if (status.div_done)
                        state_reg <= S_DIV_EMIT;
                S_DIV_EMIT:
                    if (!status.out_full || pop)
                    begin
                        if (32'(k_reg) == CLUSTERS - 1)
                            state_reg <= S_IDLE;
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_DIV;
                        end
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // start the divider on entry to S_DIV
    logic div_go_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_go_reg <= 1'b0;
        else
            div_go_reg <= (state_reg == S_IDLE && in_valid && !in_stall
                           && in_mode == MODE_FINISH)
                       || (state_reg == S_DIV_EMIT && (!status.out_full || pop)
                           && 32'(k_reg) != CLUSTERS - 1);
    end

    // search results land while in_stall holds (output slot is free by then
    // because acceptance required a free or draining slot)
    always_comb
    begin
        cmd            = '0;
        cmd.capture    = (state_reg == S_IDLE) && in_valid && !in_stall;
        cmd.load       = cmd.capture && (in_mode == MODE_LOAD);
        cmd.classify   = cmd.capture && (in_mode == MODE_CLASSIFY || in_mode == MODE_RECOLOR);
        cmd.accum      = (state_reg == S_SEARCH) && status.search_done && !recolor_reg;
        cmd.emit_class = (state_reg == S_SEARCH) && status.search_done;
        cmd.recolor    = recolor_reg;
        cmd.div_start  = div_go_reg;
        cmd.div_idx    = k_reg;
        cmd.emit_avg   = (state_reg == S_DIV_EMIT) && (!status.out_full || pop);
        cmd.last       = (32'(k_reg) == CLUSTERS - 1);
        cmd.out_pop    = pop;
    end
endmodule
`default_nettype wire

[design/kmeans_color_segmenter_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmeans_color_segmenter_core: one k-means step on BGR pixels
// Centroid load, classify/accumulate, average finish and recolor.
// ----------------------------------------------------------------------------
// Items are taken one at a time. Classify and recolor are paced by the serial
// nearest search that visits one centroid a cycle. A finish is paced by the
// restoring divider (9 steps per cluster, three channels side by side).
// A result sits in an output register; the next beat is taken only once that
// slot is empty or drains at the same edge.
`include "kmeans_color_segmenter_core_defines.svh"
module kmeans_color_segmenter_core
    import kcs_pkg::*;
#(
    parameter int CLUSTERS   = 6,
    parameter int COUNT_BITS = 22
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] mode,
    input  wire logic [2:0] index,
    input  wire logic [7:0] blue,
    input  wire logic [7:0] green,
    input  wire logic [7:0] red,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      label,
    output logic [7:0]      out_blue,
    output logic [7:0]      out_green,
    output logic [7:0]      out_red,
    output logic            last
);
    kcs_cmd_t    cmd;
    kcs_status_t status;

    kcs_ctrl #(.CLUSTERS(CLUSTERS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_mode(mode), .out_stall(out_stall), .status(status), .cmd(cmd)
    );

    kcs_datapath #(.CLUSTERS(CLUSTERS), .COUNT_BITS(COUNT_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .in_index(index), .in_blue(blue), .in_green(green), .in_red(red),
        .label(label), .out_blue(out_blue), .out_green(out_green),
        .out_red(out_red), .last(last), .valid(out_valid)
    );

    // a new result never overwrites one still held
    `KCS_ASSERT(a_no_overwrite, clk, rst_n, !((cmd.emit_class || cmd.emit_avg) && out_valid && out_stall), "result overwritten")
    // labels stay within the cluster range
    `KCS_ASSERT(a_label_range, clk, rst_n, !out_valid || (32'(label) < CLUSTERS), "label out of range")
    // a search result is taken into the output register: emit_class is followed by out_valid
    `KCS_ASSERT_NEXT(a_search_emits, clk, rst_n, cmd.emit_class, out_valid, "missing result")
endmodule
`default_nettype wire
